// ===== design/pes_pkg.sv =====
// Shared widths, request codes and table entry type for the periodic event scheduler.
`timescale 1ns / 1ps

package pes_pkg;

  localparam int ID_W   = 32;
  localparam int PER_W  = 16;
  localparam int TIME_W = 40;
  localparam int FC_W   = 7;
  localparam int REQ_W  = 2;

  localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FIRE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  period;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    logic sample;
    logic first;
  } pick_ctl_t;

endpackage

// ===== design/periodic_event_scheduler.sv =====
// Top level: request sequencer, table scan control and output register.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_tvalid/in_tready   | tuser: req_type; tdata: task_id, period, fire_count
//  out_    | out | out_tvalid/out_tready | tdata: event_id, event_time; tlast; tuser: empty
//
// Add and clear complete without leaving the idle state; a fire on an empty table goes through the emit state.
// Each event of a fire scans all stored tasks through one comparator,
// fed by the single memory read port.
// in_tready is high only while no request is in progress.
// A stalled output beat holds the sequencer before the next event is loaded.
// Reset clears the task count and control state; the table needs no clearing.
`timescale 1ns / 1ps

module periodic_event_scheduler #(
  parameter int MAX_TASKS = 64,
  parameter int MAX_FIRE  = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // task_id[31:0], period[47:32], fire_count[54:48], zero[55]
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // event_id[31:0], event_time[71:32]
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // table_empty[0]
);
  import pes_pkg::*;

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [FC_W-1:0] FIRE_LIM = FC_W'(MAX_FIRE);
  localparam logic [CW-1:0]   CNT_FULL = CW'(MAX_TASKS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [CW-1:0]     scan_r, scan_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pend_idx_r, pend_idx_nxt;
  logic [FC_W-1:0]   k_r, k_nxt;
  logic [FC_W-1:0]   n_r, n_nxt;
  logic              empty_r, empty_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic [TIME_W-1:0] out_time_r, out_time_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_empty_r, out_empty_nxt;

  logic [REQ_W-1:0]  req;
  logic [ID_W-1:0]   tid;
  logic [PER_W-1:0]  per;
  logic [FC_W-1:0]   fc;

  logic              we, re;
  logic [AW-1:0]     waddr;
  entry_t            wdata, rdata, best;
  logic [AW-1:0]     best_idx;
  pick_ctl_t         pctl;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] next_due;
  logic              is_last;

  assign req = in_tuser;
  assign tid = in_tdata[31:0];
  assign per = in_tdata[47:32];
  assign fc  = in_tdata[54:48];

  assign in_tready = (state_r == ST_IDLE);

  assign sum      = {1'b0, best.due} + (TIME_W + 1)'(best.period);
  assign next_due = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
  assign is_last  = ((k_r + FC_W'(1)) == n_r);

  assign pctl.sample = pend_r;
  assign pctl.first  = (pend_idx_r == '0);

  pes_mem #(.DEPTH(MAX_TASKS), .AW(AW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (scan_r[AW-1:0]),
    .rdata (rdata)
  );

  pes_pick #(.AW(AW)) u_pick (
    .clk      (clk),
    .ctl      (pctl),
    .cand     (rdata),
    .cand_idx (pend_idx_r),
    .best     (best),
    .best_idx (best_idx)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pend_idx_nxt  = pend_idx_r;
    k_nxt         = k_r;
    n_nxt         = n_r;
    empty_nxt     = empty_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_time_nxt  = out_time_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = cnt_r[AW-1:0];
    wdata.id      = tid;
    wdata.period  = per;
    wdata.due     = TIME_W'(per);

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          unique case (req)
            REQ_ADD: begin
              if (cnt_r < CNT_FULL) begin
                we      = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            REQ_FIRE: begin
              if (cnt_r == '0) begin
                empty_nxt = 1'b1;
                state_nxt = ST_EMIT;
              end else if (fc != '0) begin
                n_nxt     = (fc > FIRE_LIM) ? FIRE_LIM : fc;
                k_nxt     = '0;
                empty_nxt = 1'b0;
                scan_nxt  = '0;
                state_nxt = ST_SCAN;
              end
            end
            REQ_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_r < cnt_r) begin
          re           = 1'b1;
          scan_nxt     = scan_r + CW'(1);
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[AW-1:0];
        end else if (!pend_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          if (empty_r) begin
            out_id_nxt    = '0;
            out_time_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_empty_nxt = 1'b1;
            empty_nxt     = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            out_id_nxt    = best.id;
            out_time_nxt  = best.due;
            out_last_nxt  = is_last;
            out_empty_nxt = 1'b0;
            we            = 1'b1;
            waddr         = best_idx;
            wdata.id      = best.id;
            wdata.period  = best.period;
            wdata.due     = next_due;
            k_nxt         = k_r + FC_W'(1);
            scan_nxt      = '0;
            state_nxt     = is_last ? ST_IDLE : ST_SCAN;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      k_r         <= '0;
      n_r         <= '0;
      empty_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      k_r         <= k_nxt;
      n_r         <= n_nxt;
      empty_r     <= empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r  <= pend_idx_nxt;
    out_id_r    <= out_id_nxt;
    out_time_r  <= out_time_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_time_r, out_id_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_empty_r;

endmodule

// ===== design/pes_mem.sv =====
// Task table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module pes_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  pes_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output pes_pkg::entry_t rdata
);
  import pes_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/pes_pick.sv =====
// Shared compare unit: keeps the earliest entry seen so far during a table scan.
`timescale 1ns / 1ps

module pes_pick #(
  parameter int AW = 6
) (
  input  logic               clk,
  input  pes_pkg::pick_ctl_t ctl,
  input  pes_pkg::entry_t    cand,
  input  logic [AW-1:0]      cand_idx,
  output pes_pkg::entry_t    best,
  output logic [AW-1:0]      best_idx
);
  import pes_pkg::*;

  entry_t        best_r;
  logic [AW-1:0] best_idx_r;
  logic          better;

  assign better = (cand.due < best_r.due) ||
                  ((cand.due == best_r.due) && (cand.id < best_r.id));

  always_ff @(posedge clk) begin
    if (ctl.sample && (ctl.first || better)) begin
      best_r     <= cand;
      best_idx_r <= cand_idx;
    end
  end

  assign best     = best_r;
  assign best_idx = best_idx_r;

endmodule
